// ===== rtl/utf8_stream_validator_assert.svh =====
// assertion macros shared by the utf8 stream validator rtl
// depends on a clock named aclk and an active-low reset named aresetn in the using module
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define U8V_ASSERT_IMP(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (conseq)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define U8V_ASSERT_NXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define U8V_ASSERT_IMP(label, cond, conseq, msg)
`define U8V_ASSERT_NXT(label, cond, conseq, msg)
`endif
`endif

// ===== rtl/u8v_pkg.sv =====
// types and constants of the utf8 stream validator
// used by u8v_skid and utf8_stream_validator; no dependencies
`timescale 1ns / 1ps

package u8v_pkg;

    // byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // sequence lengths
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // code point limits
    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

    // one result as it travels to the output buffer
    typedef struct packed {
        logic [1:0] bytes_pending;
        logic       text_done;
        logic       still_valid;
    } result_t;

endpackage

// ===== rtl/u8v_skid.sv =====
// two-entry output buffer (output register plus skid register) for results
// depends on u8v_pkg and utf8_stream_validator_assert.svh
`timescale 1ns / 1ps
`include "utf8_stream_validator_assert.svh"

module u8v_skid
    import u8v_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            // output slot frees up: drain skid first, else take the new request
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `U8V_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid holds data with output empty")
    `U8V_ASSERT_NXT(a_stall_parks, in_valid && in_ready && out_valid_reg && !out_ready, skid_valid_reg && out_valid_reg, "request lost while output stalled")
    `U8V_ASSERT_NXT(a_skid_drains, skid_valid_reg && out_ready, !skid_valid_reg && out_valid_reg, "skid not moved to output")

endmodule

// ===== rtl/utf8_stream_validator.sv =====
// top level of the utf8 stream validator: decode state, byte checks, result buffer
// depends on u8v_pkg, u8v_skid and utf8_stream_validator_assert.svh
`timescale 1ns / 1ps
`include "utf8_stream_validator_assert.svh"

// Checks a byte stream as UTF-8, one byte per clock. Each byte on s_tdata
// (s_tlast marks the final byte of a text) gives exactly one result on m_*.
// A byte is taken on every cycle that s_tvalid and s_tready are high; its
// result is registered in the output buffer. Sustained rate is one byte per
// clock: the whole decode step for a byte is one pass of logic from the
// decode state registers into the result buffer, and s_tready only drops
// when both entries of the two-entry output buffer are full. NUL, control
// bytes other than tab, newline and carriage return, bad lead or
// continuation bytes, overlong three and four byte forms, surrogates, code
// points above 10FFFF and a sequence left open at the final byte all mark
// the text invalid. Once invalid, the text stays invalid until its final
// byte; after the final byte all state returns to reset for the next text.
// No clearing pass after reset.

module utf8_stream_validator
    import u8v_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] still_valid, [2:1] bytes_pending, [7:3] zero
    output logic       m_tlast    // text_done
);

    // decode state
    logic [1:0]      rem_reg, rem_next;
    logic [2:0]      len_reg, len_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic            err_reg, err_next;

    logic            s_accept;
    logic [CP_W-1:0] acc_shift;
    logic            cp_bad;
    logic            fail;
    result_t         res;
    result_t         out_res;

    assign s_accept = s_tvalid && s_tready;

    // code point after appending this continuation byte
    assign acc_shift = {acc_reg[CP_W-7:0], s_tdata[5:0]};

    // range checks, only meaningful on the closing byte of a sequence
    assign cp_bad = ((len_reg == SEQ_THREE) && (acc_shift < CP_MIN3))
                 || ((len_reg == SEQ_FOUR) && (acc_shift < CP_MIN4))
                 || ((acc_shift >= CP_SURR_LO) && (acc_shift <= CP_SURR_HI))
                 || (acc_shift > CP_MAX);

    always_comb begin
        rem_next = rem_reg;
        len_next = len_reg;
        acc_next = acc_reg;
        err_next = err_reg;
        fail     = 1'b0;

        // once an error is latched later bytes of the text are ignored
        if (!err_reg) begin
            if (rem_reg == 2'd0) begin
                // expecting a single byte or a lead byte
                priority if (s_tdata == 8'h00) begin
                    fail = 1'b1;
                end else if (s_tdata < ASCII_LIMIT) begin
                    if ((s_tdata < CTRL_LIMIT) && (s_tdata != CHAR_TAB)
                        && (s_tdata != CHAR_LF) && (s_tdata != CHAR_CR)) begin
                        fail = 1'b1;
                    end
                end else if ((s_tdata >= LEAD2_MIN) && (s_tdata <= LEAD2_MAX)) begin
                    len_next = SEQ_TWO;
                    acc_next = {{(CP_W-5){1'b0}}, s_tdata[4:0]};
                    rem_next = 2'd1;
                end else if ((s_tdata >= LEAD3_MIN) && (s_tdata <= LEAD3_MAX)) begin
                    len_next = SEQ_THREE;
                    acc_next = {{(CP_W-4){1'b0}}, s_tdata[3:0]};
                    rem_next = 2'd2;
                end else if ((s_tdata >= LEAD4_MIN) && (s_tdata <= LEAD4_MAX)) begin
                    len_next = SEQ_FOUR;
                    acc_next = {{(CP_W-3){1'b0}}, s_tdata[2:0]};
                    rem_next = 2'd3;
                end else begin
                    fail = 1'b1;
                end
            end else if (s_tdata[7:6] != CONT_TAG) begin
                fail = 1'b1;
            end else begin
                acc_next = acc_shift;
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1) begin
                    // sequence closes here
                    if (cp_bad) begin
                        fail = 1'b1;
                    end else begin
                        len_next = SEQ_NONE;
                        acc_next = '0;
                    end
                end
            end
        end

        // a sequence still open at the final byte spoils the text
        if (s_tlast && (rem_next != 2'd0)) begin
            fail = 1'b1;
        end

        if (fail) begin
            err_next = 1'b1;
            rem_next = 2'd0;
            len_next = SEQ_NONE;
            acc_next = '0;
        end

        res.still_valid   = !err_next;
        res.text_done     = s_tlast;
        res.bytes_pending = err_next ? 2'd0 : rem_next;

        // final byte: start the next text from reset
        if (s_tlast) begin
            rem_next = 2'd0;
            len_next = SEQ_NONE;
            acc_next = '0;
            err_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            len_reg <= SEQ_NONE;
            acc_reg <= '0;
            err_reg <= 1'b0;
        end else if (s_accept) begin
            rem_reg <= rem_next;
            len_reg <= len_next;
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

    // result buffer parts the two handshakes
    u8v_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {5'b00000, out_res.bytes_pending, out_res.still_valid};
    assign m_tlast = out_res.text_done;

    `U8V_ASSERT_IMP(a_open_seq_clean, rem_reg != 2'd0, !err_reg && (len_reg != SEQ_NONE), "open sequence alongside error")
    `U8V_ASSERT_NXT(a_last_clears, s_accept && s_tlast, (rem_reg == 2'd0) && !err_reg && (len_reg == SEQ_NONE) && (acc_reg == '0), "state not cleared after final byte")
    `U8V_ASSERT_IMP(a_pending_valid, m_tvalid && (m_tdata[2:1] != 2'd0), m_tdata[0] && !m_tlast, "pending bytes reported on invalid or finished text")

endmodule
